@@ rtl/mfap_pkg.sv @@
package mfap_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = 2 * VW;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_RUN   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] REG_VCOUNT = 2'd0;
    localparam logic [1:0] REG_SOURCE = 2'd1;
    localparam logic [1:0] REG_SINK   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDWAIT,
        S_BINIT,
        S_BPOP,
        S_BSCAN,
        S_BTRD,
        S_BTCHK,
        S_AUGF,
        S_AUGRD,
        S_AUGWR,
        S_DONE
    } t_state;

    function automatic logic f_positive(input logic [63:0] x);
        return (x != 64'd0) && !x[63];
    endfunction

endpackage

@@ rtl/mfap_ram.sv @@
module mfap_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [mfap_pkg::AW-1:0]   i_waddr,
    input  logic [63:0]               i_wdata,
    input  logic [mfap_pkg::AW-1:0]   i_raddr,
    output logic [63:0]               o_rdata
);

    logic [63:0] r_mem [0:(1 << mfap_pkg::AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/max_flow_augmenting_path.sv @@
// Edmonds-Karp maximum flow over a 16 x 16 matrix of signed 64-bit residual
// capacities held in a single-port-read RAM. A write transaction yields no
// result; a read transaction returns the addressed cell. A run transaction
// repeats a breadth-first search, reading one matrix cell per cycle, then
// walks the parent chain twice, once for the bottleneck and once to update
// forward and reverse cells. The block accepts nothing while a run is busy
// or while a result transaction waits.
// tdata in: func[1:0], from_vertex[5:2], to_vertex[9:6], capacity_in[73:10].
// tdata out: status[0], flow_total[63:1], cell_value[127:64].
module max_flow_augmenting_path (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [79:0]  i_s_axis_tdata,   // func, from_vertex, to_vertex, capacity_in
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // status, flow_total, cell_value
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int VW = mfap_pkg::VW;
    localparam int AW = mfap_pkg::AW;

    logic [4:0]     r_vcount;
    logic [VW-1:0]  r_src, r_snk;
    mfap_pkg::t_state r_state, n_state;

    logic [VW-1:0]  r_parent [0:mfap_pkg::MAX_VERTICES-1];
    logic           r_visited [0:mfap_pkg::MAX_VERTICES-1];
    logic [VW-1:0]  r_queue [0:mfap_pkg::MAX_VERTICES-1];
    logic [VW:0]    r_head, r_tail;
    logic [VW-1:0]  r_u, r_v, r_w;
    logic [VW:0]    r_steps;
    logic [63:0]    r_bott, r_flow;
    logic           r_ovalid;
    logic [127:0]   r_odata;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [63:0]    wdata, rdata;

    logic [1:0]     in_func;
    logic [VW-1:0]  in_from, in_to;
    logic [63:0]    in_cap;
    logic           acc;

    assign in_func = i_s_axis_tdata[1:0];
    assign in_from = i_s_axis_tdata[5:2];
    assign in_to   = i_s_axis_tdata[9:6];
    assign in_cap  = i_s_axis_tdata[73:10];

    assign o_s_axis_tready = (r_state == mfap_pkg::S_IDLE) && !r_ovalid;
    assign acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata = r_odata;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            mfap_pkg::REG_VCOUNT: prdata = {27'd0, r_vcount};
            mfap_pkg::REG_SOURCE: prdata = {28'd0, r_src};
            mfap_pkg::REG_SINK:   prdata = {28'd0, r_snk};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 5'd16;
            r_src <= '0;
            r_snk <= 4'd15;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                mfap_pkg::REG_VCOUNT: r_vcount <= pwdata[4:0];
                mfap_pkg::REG_SOURCE: r_src <= pwdata[3:0];
                mfap_pkg::REG_SINK:   r_snk <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    mfap_ram u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [VW:0] nv;
    logic        bad_args;
    logic [VW:0] v_ext;
    logic        bott_end;
    logic [63:0] rsum;
    logic [64:0] fsum;

    assign nv = r_vcount[VW:0];
    assign bad_args = (r_vcount == 5'd0) || (r_vcount > 5'(mfap_pkg::MAX_VERTICES))
        || ({1'b0, r_src} >= nv) || ({1'b0, r_snk} >= nv);
    assign v_ext = {1'b0, r_v};
    assign bott_end = (r_w == r_src) || (r_steps >= nv);
    assign rsum = rdata + r_bott;
    assign fsum = {1'b0, r_flow} + {1'b0, r_bott};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfap_pkg::S_IDLE: begin
                if (acc && in_func == mfap_pkg::FUNC_READ) begin
                    n_state = mfap_pkg::S_RDWAIT;
                end else if (acc && in_func == mfap_pkg::FUNC_RUN) begin
                    n_state = (bad_args || r_src == r_snk) ? mfap_pkg::S_DONE
                                                           : mfap_pkg::S_BINIT;
                end
            end
            mfap_pkg::S_RDWAIT: n_state = mfap_pkg::S_IDLE;
            mfap_pkg::S_BINIT:  n_state = mfap_pkg::S_BPOP;
            mfap_pkg::S_BPOP: begin
                if (r_head >= r_tail) begin
                    n_state = mfap_pkg::S_DONE;
                end else if (r_queue[r_head[VW-1:0]] == r_snk) begin
                    n_state = mfap_pkg::S_BTRD;
                end else begin
                    n_state = mfap_pkg::S_BSCAN;
                end
            end
            mfap_pkg::S_BSCAN: begin
                if (v_ext + 1'b1 >= nv) begin
                    n_state = mfap_pkg::S_BPOP;
                end
            end
            mfap_pkg::S_BTRD: begin
                if (bott_end) begin
                    n_state = (r_w == r_src && r_bott != 64'd0) ? mfap_pkg::S_AUGF
                                                                : mfap_pkg::S_DONE;
                end else begin
                    n_state = mfap_pkg::S_BTCHK;
                end
            end
            mfap_pkg::S_BTCHK: begin
                n_state = mfap_pkg::f_positive(rdata) ? mfap_pkg::S_BTRD
                                                      : mfap_pkg::S_DONE;
            end
            mfap_pkg::S_AUGF: begin
                n_state = bott_end ? mfap_pkg::S_BINIT : mfap_pkg::S_AUGRD;
            end
            mfap_pkg::S_AUGRD:  n_state = mfap_pkg::S_AUGWR;
            mfap_pkg::S_AUGWR:  n_state = mfap_pkg::S_AUGF;
            mfap_pkg::S_DONE:   n_state = mfap_pkg::S_IDLE;
            default:            n_state = mfap_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        we = 1'b0;
        waddr = {in_from, in_to};
        wdata = in_cap;
        raddr = {in_from, in_to};
        unique case (r_state)
            mfap_pkg::S_IDLE: we = acc && in_func == mfap_pkg::FUNC_WRITE;
            mfap_pkg::S_BPOP: raddr = {r_queue[r_head[VW-1:0]], {VW{1'b0}}};
            mfap_pkg::S_BSCAN: raddr = {r_u, VW'(r_v + 1'b1)};
            mfap_pkg::S_BTRD: raddr = {r_parent[r_w], r_w};
            mfap_pkg::S_AUGF: raddr = {r_parent[r_w], r_w};
            mfap_pkg::S_AUGRD: begin
                we = 1'b1;
                waddr = {r_u, r_w};
                wdata = rdata - r_bott;
                raddr = {r_w, r_u};
            end
            mfap_pkg::S_AUGWR: begin
                we = 1'b1;
                waddr = {r_w, r_u};
                wdata = (!rdata[63] && rsum > mfap_pkg::SMAX) ? mfap_pkg::SMAX : rsum;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfap_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < mfap_pkg::MAX_VERTICES; i++) begin
                r_visited[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                mfap_pkg::S_IDLE: begin
                    r_flow <= '0;
                    if (acc && in_func == mfap_pkg::FUNC_RUN && bad_args) begin
                        r_odata <= {64'd0, 63'd0, 1'b1};
                    end
                end
                mfap_pkg::S_RDWAIT: begin
                    r_ovalid <= 1'b1;
                    r_odata <= {rdata, 63'd0, 1'b0};
                end
                mfap_pkg::S_BINIT: begin
                    for (int i = 0; i < mfap_pkg::MAX_VERTICES; i++) begin
                        r_visited[i] <= (VW'(i) == r_src);
                        r_parent[i] <= r_src;
                    end
                    r_queue[0] <= r_src;
                    r_head <= '0;
                    r_tail <= (VW+1)'(1);
                    r_odata <= {64'd0, r_flow[62:0], 1'b0};
                end
                mfap_pkg::S_BPOP: begin
                    r_u <= r_queue[r_head[VW-1:0]];
                    r_head <= r_head + 1'b1;
                    r_v <= '0;
                    r_w <= r_snk;
                    r_bott <= '0;
                    r_steps <= '0;
                end
                mfap_pkg::S_BSCAN: begin
                    if (!r_visited[r_v] && mfap_pkg::f_positive(rdata)) begin
                        r_visited[r_v] <= 1'b1;
                        r_parent[r_v] <= r_u;
                        if (r_tail < (VW+1)'(mfap_pkg::MAX_VERTICES)) begin
                            r_queue[r_tail[VW-1:0]] <= r_v;
                            r_tail <= r_tail + 1'b1;
                        end
                    end
                    r_v <= VW'(r_v + 1'b1);
                end
                mfap_pkg::S_BTRD: begin
                    r_u <= r_parent[r_w];
                    if (bott_end) begin
                        r_w <= r_snk;
                        r_steps <= '0;
                    end
                end
                mfap_pkg::S_BTCHK: begin
                    if (r_bott == 64'd0 || rdata < r_bott) begin
                        r_bott <= rdata;
                    end
                    r_w <= r_u;
                    r_steps <= r_steps + 1'b1;
                end
                mfap_pkg::S_AUGF: begin
                    r_u <= r_parent[r_w];
                    if (bott_end) begin
                        r_flow <= fsum > {1'b0, mfap_pkg::SMAX} ? mfap_pkg::SMAX
                                                                : fsum[63:0];
                    end
                end
                mfap_pkg::S_AUGWR: begin
                    r_w <= r_u;
                    r_steps <= r_steps + 1'b1;
                end
                mfap_pkg::S_DONE: begin
                    r_ovalid <= 1'b1;
                    if (!bad_args) begin
                        r_odata <= {64'd0, r_flow[62:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ sim/mfap_checker.sv @@
`timescale 1ns / 100ps

module mfap_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [79:0]  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [127:0] i_out_data,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic         i_pready,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output int           o_pending,
    output int           o_errors
);

    typedef struct packed {
        logic [63:0] cval;
        logic [62:0] flow;
        logic        status;
    } t_answer;

    logic [63:0] cells [mfap_pkg::MAX_VERTICES][mfap_pkg::MAX_VERTICES];
    logic [4:0]  num_vertices = 5'd16;
    logic [3:0]  src_vertex = 4'd0;
    logic [3:0]  dst_vertex = 4'd15;
    int          parent [mfap_pkg::MAX_VERTICES];
    bit          seen [mfap_pkg::MAX_VERTICES];
    int          fifo [mfap_pkg::MAX_VERTICES];
    t_answer     answers_due [$];
    int          err_count = 0;
    int          pend_count = 0;

    assign o_errors  = err_count;
    assign o_pending = pend_count;

    function automatic bit is_positive(input logic [63:0] x);
        return (x != 64'd0) && !x[63];
    endfunction

    function automatic bit find_path(input int n, input int s, input int t);
        int head;
        int tail;
        int u;
        head = 0;
        tail = 1;
        for (int v = 0; v < n; v++) begin
            parent[v] = mfap_pkg::MAX_VERTICES;
            seen[v] = 0;
        end
        seen[s] = 1;
        fifo[0] = s;
        while (head < tail) begin
            u = fifo[head];
            head++;
            if (u == t) return 1;
            for (int v = 0; v < n; v++) begin
                if (seen[v] || !is_positive(cells[u][v])) continue;
                seen[v] = 1;
                parent[v] = u;
                if (tail < mfap_pkg::MAX_VERTICES) begin
                    fifo[tail] = v;
                    tail++;
                end
            end
        end
        return seen[t];
    endfunction

    function automatic logic [63:0] path_minimum(input int n, input int s, input int t);
        logic [63:0] b;
        int v;
        int u;
        int steps;
        b = 64'd0;
        v = t;
        steps = 0;
        while (v != s && steps < n) begin
            u = parent[v];
            if (u >= n || !is_positive(cells[u][v])) return 64'd0;
            if (b == 64'd0 || cells[u][v] < b) b = cells[u][v];
            v = u;
            steps++;
        end
        return (v == s) ? b : 64'd0;
    endfunction

    function automatic void push_flow(input int n, input int s, input int t,
                                      input logic [63:0] b);
        int v;
        int u;
        int steps;
        logic [63:0] r;
        v = t;
        steps = 0;
        while (v != s && steps < n) begin
            u = parent[v];
            if (u >= n) return;
            cells[u][v] = cells[u][v] - b;
            r = cells[v][u];
            if (!r[63] && r + b > mfap_pkg::SMAX) cells[v][u] = mfap_pkg::SMAX;
            else cells[v][u] = r + b;
            v = u;
            steps++;
        end
    endfunction

    function automatic t_answer max_flow();
        t_answer a;
        logic [63:0] total;
        logic [63:0] b;
        int n;
        int s;
        int t;
        a = '0;
        n = int'(num_vertices);
        s = int'(src_vertex);
        t = int'(dst_vertex);
        if (n == 0 || n > mfap_pkg::MAX_VERTICES || s >= n || t >= n) begin
            a.status = 1'b1;
            return a;
        end
        total = 64'd0;
        if (s != t) begin
            while (find_path(n, s, t)) begin
                b = path_minimum(n, s, t);
                if (b == 64'd0) break;
                push_flow(n, s, t, b);
                if (total + b > mfap_pkg::SMAX) total = mfap_pkg::SMAX;
                else total = total + b;
            end
        end
        a.flow = total[62:0];
        return a;
    endfunction

    always @(posedge i_clk) begin
        logic [1:0] func;
        logic [3:0] fr;
        logic [3:0] to;
        t_answer    a;
        t_answer    got;
        if (!i_rst_n) begin
            num_vertices = 5'd16;
            src_vertex   = 4'd0;
            dst_vertex   = 4'd15;
            answers_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    mfap_pkg::REG_VCOUNT: num_vertices = i_pwdata[4:0];
                    mfap_pkg::REG_SOURCE: src_vertex = i_pwdata[3:0];
                    mfap_pkg::REG_SINK:   dst_vertex = i_pwdata[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                func = i_in_data[1:0];
                fr   = i_in_data[5:2];
                to   = i_in_data[9:6];
                if (func == mfap_pkg::FUNC_WRITE) begin
                    cells[fr][to] = i_in_data[73:10];
                end else if (func == mfap_pkg::FUNC_READ) begin
                    a = '0;
                    a.cval = cells[fr][to];
                    answers_due.push_back(a);
                end else if (func == mfap_pkg::FUNC_RUN) begin
                    answers_due.push_back(max_flow());
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (answers_due.size() == 0) begin
                    $error("result transaction with nothing expected");
                    err_count++;
                end else begin
                    a = answers_due.pop_front();
                    if (got.status !== a.status) begin
                        $error("status expected %0d got %0d", a.status, got.status);
                        err_count++;
                    end
                    if (got.flow !== a.flow) begin
                        $error("flow_total expected %0d got %0d", a.flow, got.flow);
                        err_count++;
                    end
                    if (got.cval !== a.cval) begin
                        $error("cell_value expected %0d got %0d",
                               $signed(a.cval), $signed(got.cval));
                        err_count++;
                    end
                end
            end
        end
        pend_count = answers_due.size();
    end

endmodule

@@ sim/tb_max_flow_augmenting_path.sv @@
`timescale 1ns / 100ps

module tb_max_flow_augmenting_path;

    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [79:0]  s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [127:0] m_data;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         hold_go = 1'b0;
    int           hold_left = 0;
    int           stall_left = 0;
    int           stall_pct = 0;
    int           burst_left = 0;
    int           pending;
    int           errors;
    int           sent = 0;

    max_flow_augmenting_path u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    mfap_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_valid),
        .i_in_ready  (s_ready),
        .i_in_data   (s_data),
        .i_out_valid (m_valid),
        .i_out_ready (m_ready),
        .i_out_data  (m_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("== FAIL ==");
        $finish;
    end

    // The receiver stalls in segments of random density, and holds off
    // completely for a long stretch when asked.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_left <= $urandom_range(5, 60);
                case ($urandom_range(0, 2))
                    0: stall_pct <= 0;
                    1: stall_pct <= 30;
                    default: stall_pct <= 70;
                endcase
            end else begin
                stall_left <= stall_left - 1;
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [3:0] fr,
                             input logic [3:0] to, input logic [63:0] cap);
        int gap;
        s_valid <= 1'b1;
        s_data <= {6'd0, cap, to, fr, func};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (func != FUNC_SPARE) sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic [4:0] n, input logic [3:0] s, input logic [3:0] t);
        drain();
        set_register(mfap_pkg::REG_VCOUNT, ({$urandom} & ~32'h1F) | 32'(n));
        set_register(mfap_pkg::REG_SOURCE, ({$urandom} & ~32'hF) | 32'(s));
        set_register(mfap_pkg::REG_SINK, ({$urandom} & ~32'hF) | 32'(t));
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_capacity();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 64'($urandom_range(1, 100));
            6: return 64'd0;
            7: return {1'b1, 31'($urandom), $urandom};
            8: return {1'b0, 31'($urandom), $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int n;
        int s;
        int t;
        int edges;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < mfap_pkg::MAX_VERTICES; r++)
            for (int c = 0; c < mfap_pkg::MAX_VERTICES; c++)
                send_item(mfap_pkg::FUNC_WRITE, 4'(r), 4'(c), 64'd0);

        // Two disjoint paths at full capacity make the total saturate and the
        // reverse cell on one of them saturate as well.
        send_item(mfap_pkg::FUNC_WRITE, 4'd0, 4'd1, mfap_pkg::SMAX);
        send_item(mfap_pkg::FUNC_WRITE, 4'd1, 4'd15, mfap_pkg::SMAX);
        send_item(mfap_pkg::FUNC_WRITE, 4'd0, 4'd2, mfap_pkg::SMAX);
        send_item(mfap_pkg::FUNC_WRITE, 4'd2, 4'd15, mfap_pkg::SMAX);
        send_item(mfap_pkg::FUNC_WRITE, 4'd1, 4'd0, 64'd5);
        send_item(mfap_pkg::FUNC_WRITE, 4'd3, 4'd4, 64'h8000_0000_0000_0000);
        send_item(mfap_pkg::FUNC_WRITE, 4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(mfap_pkg::FUNC_READ, 4'd3, 4'd4, 64'd0);
        send_item(mfap_pkg::FUNC_READ, 4'd15, 4'd15, 64'd0);
        send_item(FUNC_SPARE, 4'd7, 4'd7, 64'd1);
        send_item(mfap_pkg::FUNC_RUN, 4'd0, 4'd0, 64'd0);
        send_item(mfap_pkg::FUNC_READ, 4'd1, 4'd0, 64'd0);
        send_item(mfap_pkg::FUNC_READ, 4'd0, 4'd1, 64'd0);
        send_item(mfap_pkg::FUNC_RUN, 4'd0, 4'd0, 64'd0);
        configure(5'd0, 4'd0, 4'd0);
        send_item(mfap_pkg::FUNC_RUN, 4'd0, 4'd0, 64'd0);
        configure(5'd1, 4'd0, 4'd0);
        send_item(mfap_pkg::FUNC_RUN, 4'd0, 4'd0, 64'd0);
        configure(5'd16, 4'd15, 4'd0);
        send_item(mfap_pkg::FUNC_RUN, 4'd0, 4'd0, 64'd0);
        configure(5'd31, 4'd0, 4'd1);
        send_item(mfap_pkg::FUNC_RUN, 4'd0, 4'd0, 64'd0);
        configure(5'd4, 4'd5, 4'd1);
        send_item(mfap_pkg::FUNC_RUN, 4'd0, 4'd0, 64'd0);

        // Long receiver hold-off while reads keep arriving.
        drain();
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        for (int k = 0; k < 30; k++)
            send_item(mfap_pkg::FUNC_READ, 4'($urandom), 4'($urandom), 64'd0);

        while (sent < 1100) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n = $urandom_range(2, 6);
                6, 7: n = $urandom_range(7, 10);
                8: n = 16;
                default: n = $urandom_range(0, 31);
            endcase
            s = (n > 0 && n <= 16) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
            t = (n > 0 && n <= 16) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
            if ($urandom_range(0, 9) == 0) s = $urandom_range(0, 15);
            configure(5'(n), 4'(s), 4'(t));
            edges = $urandom_range(4, 24);
            for (int k = 0; k < edges; k++) begin
                if (n > 0 && n <= 16 && $urandom_range(0, 4) != 0)
                    send_item(mfap_pkg::FUNC_WRITE, 4'($urandom_range(0, n - 1)),
                              4'($urandom_range(0, n - 1)), random_capacity());
                else
                    send_item(mfap_pkg::FUNC_WRITE, 4'($urandom), 4'($urandom),
                              random_capacity());
                if ($urandom_range(0, 7) == 0)
                    send_item(mfap_pkg::FUNC_READ, 4'($urandom), 4'($urandom), 64'd0);
                if ($urandom_range(0, 30) == 0)
                    send_item(FUNC_SPARE, 4'($urandom), 4'($urandom), random_capacity());
            end
            send_item(mfap_pkg::FUNC_RUN, 4'($urandom), 4'($urandom), random_capacity());
            repeat ($urandom_range(1, 5))
                send_item(mfap_pkg::FUNC_READ, 4'($urandom), 4'($urandom), 64'd0);
            if ($urandom_range(0, 1) == 0)
                send_item(mfap_pkg::FUNC_RUN, 4'($urandom), 4'($urandom), 64'd0);
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mfap_pkg.sv
rtl/mfap_ram.sv
rtl/max_flow_augmenting_path.sv
sim/mfap_checker.sv
sim/tb_max_flow_augmenting_path.sv
